### hdl/audio_tempo_averaged_hysteresis_macros.svh
// Assertion macros for the tempo controller.
// No dependencies.
`ifndef AUDIO_TEMPO_AVERAGED_HYSTERESIS_MACROS_SVH
`define AUDIO_TEMPO_AVERAGED_HYSTERESIS_MACROS_SVH
// Implication checked every cycle outside reset.
`define ATAH_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ATAH_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

### hdl/ata_pkg.sv
// Shared types and constants of the tempo controller.
// No dependencies.
package ata_pkg;
   localparam int unsigned QW = 48;
   localparam logic [19:0] Q16_ONE = 20'd65536;
   localparam logic [19:0] RATIO_MAX = 20'hFFFFF;
   localparam logic [19:0] TEMPO_MIN = 20'd3277;
   localparam logic [19:0] TEMPO_MAX = 20'd655360;
   localparam logic [19:0] SNAP_LO = 20'd58983;
   localparam logic [19:0] SNAP_HI = 20'd72089;
   localparam logic [1:0] REG_LATENCY = 2'd0;
   localparam logic [1:0] REG_AVG_LEN = 2'd1;
   localparam logic [1:0] REG_MIN_OK = 2'd2;
   localparam logic [1:0] REG_DIVIDER = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_RATIO, ST_RING, ST_AVG, ST_CLAMP,
      ST_GOAL, ST_STEP, ST_APPLY, ST_FINISH, ST_OUT
   } state_type;

   // Request to the shared divider.
   typedef struct packed {
      logic          start;
      logic [QW-1:0] num;
      logic [QW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [QW-1:0] quo;
   } div_rsp_type;
endpackage

### hdl/ata_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ata_pkg.
module ata_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ata_pkg::div_req_type req,
   output ata_pkg::div_rsp_type rsp
);
   import ata_pkg::*;

   logic [QW-1:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [QW:0]   trial;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, num_ff[QW-1]} - {1'b0, den_ff};
      if (req.start) begin
         num_in = req.num;
         den_in = req.den;
         rem_in = '0;
         cnt_in = 6'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[QW]) begin
            rem_in = trial[QW-1:0];
            num_in = {num_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[QW-2:0], num_ff[QW-1]};
            num_in = {num_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo = num_ff;
endmodule

### hdl/audio_tempo_averaged_hysteresis.sv
// Averaged tempo controller with unity hysteresis, top level.
// Depends on ata_pkg, ata_divider and the assertion macro header.
//
// Each request beat carries the buffer fill. One response beat carries the
// tempo in unsigned Q4.16 and the unity flag. Work on one beat runs through a
// small sequencer around a single shared 48-bit restoring divider that gives
// one quotient bit per cycle. Each update uses the divider up to four times
// (fill ratio, average, goal, compensation step); the average division is
// skipped when the ring sum is zero. A new request is taken while idle once
// the response register is free. Configuration writes are taken only between
// updates. After reset, and after every write of avg_len, a clearing pass
// zeroes all MAX_AVG_LEN entries of the ratio ring while no request is
// taken. The ring is a memory with one read and one write port and
// registered read data.
module audio_tempo_averaged_hysteresis #(
   parameter int MAX_AVG_LEN = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [17:0] req_buffer_fill,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_tempo_q16,
   output logic        rsp_unity_mode,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ata_pkg::*;
`include "audio_tempo_averaged_hysteresis_macros.svh"

   localparam int AW = $clog2(MAX_AVG_LEN);
   localparam int LW = $clog2(MAX_AVG_LEN + 1);

   // Configuration registers.
   logic [9:0] lat_ff;
   logic [6:0] len_cfg_ff, min_ok_ff;
   logic [7:0] cdiv_ff;
   logic csr_fire, len_wr;

   state_type state_ff, state_in;

   // Writes are only taken while no update is running.
   assign csr_ready = state_ff == ST_IDLE;
   assign csr_fire = csr_valid && csr_ready;
   assign len_wr = csr_fire && csr_index == REG_AVG_LEN;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= 10'd100;
         len_cfg_ff <= 7'd50;
         min_ok_ff <= 7'd50;
         cdiv_ff <= 8'd100;
      end else if (csr_fire) begin
         case (csr_index)
            REG_LATENCY: lat_ff <= csr_data[9:0];
            REG_AVG_LEN: len_cfg_ff <= csr_data[6:0];
            REG_MIN_OK:  min_ok_ff <= csr_data[6:0];
            REG_DIVIDER: cdiv_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Effective average length, limited to 1..MAX_AVG_LEN.
   logic [LW-1:0] len;
   always_comb begin
      if (len_cfg_ff == 7'd0) len = LW'(1);
      else if (32'(len_cfg_ff) > 32'(MAX_AVG_LEN)) len = LW'(MAX_AVG_LEN);
      else len = LW'(len_cfg_ff);
   end

   // Base target in Q20.8: lat_ff * 48 << 8 = lat_ff * 12288.
   logic [27:0] base;
   assign base = 28'(lat_ff) * 28'd12288;

   logic [17:0] fill_ff;
   logic [19:0] ratio_ff, t_ff, tempo_out_ff;
   logic [26:0] sum_ff;
   logic [27:0] target_ff;
   // The goal reaches about 2^36 at the lowest tempo, so it keeps full width.
   logic [QW-1:0] goal_ff;
   logic [AW-1:0] pos_ff, clr_ff;
   logic [6:0] ok_ff;
   logic unity_ff, unity_out_ff, rsp_valid_ff;
   logic sent_ff;
   logic [19:0] ring_rd_ff;
   logic [19:0] ring_mem [MAX_AVG_LEN];

   div_req_type dreq;
   div_rsp_type drsp;
   ata_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (32'(clr_ff) == MAX_AVG_LEN - 1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (len_wr) state_in = ST_CLEAR;
            else if (req_valid && !rsp_valid_ff) state_in = ST_RATIO;
         end
         ST_RATIO: if (drsp.done && sent_ff) state_in = ST_RING;
         ST_RING:  state_in = ST_AVG;
         ST_AVG:   if ((drsp.done && sent_ff) || sum_ff == '0) state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_GOAL;
         ST_GOAL:  if (drsp.done && sent_ff) state_in = ST_STEP;
         ST_STEP:  if (drsp.done && sent_ff) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Divider operands for each stage.
   logic [QW-1:0] diff_mag;
   logic diff_neg;
   assign diff_neg = goal_ff < QW'(target_ff);
   assign diff_mag = diff_neg ? QW'(target_ff) - goal_ff : goal_ff - QW'(target_ff);

   always_comb begin
      dreq.start = 1'b0;
      dreq.num = '0;
      dreq.den = 48'd1;
      case (state_ff)
         ST_RATIO: begin
            dreq.start = !sent_ff;
            dreq.num = {6'd0, fill_ff, 24'd0};
            dreq.den = (target_ff == '0) ? 48'd1 : 48'(target_ff);
         end
         ST_AVG: begin
            dreq.start = !sent_ff && sum_ff != '0;
            dreq.num = 48'(sum_ff) + 48'(len >> 1);
            dreq.den = 48'(len);
         end
         ST_GOAL: begin
            // base < 2^24 for lat_ff <= 1023, so base << 24 fits in 48 bits.
            dreq.start = !sent_ff;
            dreq.num = {base[23:0], 24'd0} + 48'(t_ff >> 1);
            dreq.den = 48'(t_ff);
         end
         ST_STEP: begin
            dreq.start = !sent_ff;
            dreq.num = diff_mag;
            dreq.den = (cdiv_ff == '0) ? 48'd1 : 48'(cdiv_ff);
         end
         default: ;
      endcase
   end

   // Ring memory, one write and one registered read.
   logic ring_we;
   logic [AW-1:0] ring_wa;
   logic [19:0] ring_wd;
   always_comb begin
      ring_we = state_ff == ST_CLEAR || state_ff == ST_RING;
      ring_wa = (state_ff == ST_CLEAR) ? clr_ff : pos_ff;
      ring_wd = (state_ff == ST_CLEAR) ? 20'd0 : ratio_ff;
   end
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_wa] <= ring_wd;
      ring_rd_ff <= ring_mem[pos_ff];
   end

   // Datapath and hysteresis.
   logic within_ok, within_hold, snap;
   logic [27:0] nt;
   logic [33:0] t34;
   logic [6:0] ok_nx;
   assign t34 = 34'(t_ff);
   assign within_ok = t34 * 34'd104 >= 34'd6553600 && t34 * 34'd100 <= 34'd6815744;
   assign within_hold = t34 * 34'd120 >= 34'd6553600 && t34 * 34'd100 <= 34'd7864320;
   assign snap = t_ff >= SNAP_LO && t_ff <= SNAP_HI
      && 32'(target_ff) * 32'd10 >= 32'(base) * 32'd9
      && 32'(target_ff) * 32'd10 <= 32'(base) * 32'd11;
   // A downward step never exceeds the target. An upward step wraps at 28 bits
   // like the target itself, so only the low quotient bits matter.
   assign nt = diff_neg ? (drsp.quo[27:0] > target_ff ? 28'd0 : target_ff - drsp.quo[27:0])
                        : target_ff + drsp.quo[27:0];
   assign ok_nx = !within_ok ? 7'd0 : (ok_ff == 7'd127) ? ok_ff : ok_ff + 7'd1;

   logic [AW-1:0] cur_pos;
   assign cur_pos = (32'(pos_ff) >= 32'(len)) ? '0 : pos_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !rsp_valid_ff) fill_ff <= req_buffer_fill;
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         pos_ff <= '0;
         sum_ff <= '0;
         target_ff <= 28'd1228800;
         ok_ff <= '0;
         unity_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sent_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (drsp.done) sent_ff <= 1'b0;
         else if (dreq.start) sent_ff <= 1'b1;
         case (state_ff)
            ST_IDLE: begin
               clr_ff <= '0;
               if (len_wr) begin
                  pos_ff <= '0;
                  sum_ff <= '0;
               end else if (req_valid && !rsp_valid_ff) begin
                  pos_ff <= cur_pos;
               end
            end
            ST_CLEAR: clr_ff <= clr_ff + AW'(1);
            ST_RATIO: if (drsp.done && sent_ff)
               ratio_ff <= (target_ff == '0 || drsp.quo > 48'(RATIO_MAX)) ? RATIO_MAX
                           : drsp.quo[19:0];
            ST_RING: begin
               sum_ff <= sum_ff - 27'(ring_rd_ff) + 27'(ratio_ff);
               pos_ff <= (32'(pos_ff) + 1 >= 32'(len)) ? '0 : pos_ff + AW'(1);
            end
            ST_AVG: begin
               if (sum_ff == '0) t_ff <= Q16_ONE;
               else if (drsp.done && sent_ff)
                  t_ff <= (drsp.quo > 48'(RATIO_MAX)) ? RATIO_MAX : drsp.quo[19:0];
            end
            ST_CLAMP: begin
               if (t_ff < TEMPO_MIN) t_ff <= TEMPO_MIN;
               else if (t_ff > TEMPO_MAX) t_ff <= TEMPO_MAX;
            end
            ST_GOAL: if (drsp.done && sent_ff) goal_ff <= drsp.quo;
            ST_STEP: if (drsp.done && sent_ff) target_ff <= nt;
            ST_APPLY: begin
               if (snap) target_ff <= base;
               // Entry is decided on the updated count; leaving unity mode
               // never re-enters it in the same update.
               if (!unity_ff) begin
                  ok_ff <= ok_nx;
                  if (ok_nx >= min_ok_ff) unity_ff <= 1'b1;
               end else if (!within_hold) begin
                  unity_ff <= 1'b0;
                  ok_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT) begin
         tempo_out_ff <= unity_ff ? Q16_ONE : t_ff;
         unity_out_ff <= unity_ff;
      end
   end

   assign req_ready = state_ff == ST_IDLE && !rsp_valid_ff && !len_wr;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tempo_q16 = tempo_out_ff;
   assign rsp_unity_mode = unity_out_ff;

   `ATAH_ASSERT_IMP(a_unity_tempo, clock, reset, rsp_valid && rsp_unity_mode, rsp_tempo_q16 == Q16_ONE)
   `ATAH_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_ready)
   `ATAH_ASSERT_NEXT(a_out_raises_valid, clock, reset, state_ff == ST_OUT, rsp_valid)
endmodule
